FILE: rtl/core/echo_pulse_trimmed_mean_ranger_assert.svh
// ----------------------------------------------------------------------------
// echo pulse ranger assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_TRIMMED_MEAN_RANGER_ASSERT_SVH
`define ECHO_PULSE_TRIMMED_MEAN_RANGER_ASSERT_SVH

// same-cycle implication
`define EPR_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPR_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/epr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_pkg
// shared constants, codes and types of the echo pulse ranger
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int unsigned SAMPLES   = 5;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned DIST_W    = 17;
  localparam int unsigned TOT_W     = 32;
  localparam int unsigned DVD_W     = 25;
  localparam int unsigned DVS_W     = 8;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TRIM_MIN  = 3;

  localparam logic [TIME_W-1:0] MIN_PULSE_RST = 16'd100;
  localparam logic [TIME_W-1:0] MIN_ECHO_RST  = 16'd117;
  localparam logic [TIME_W-1:0] MAX_ECHO_RST  = 16'd23529;
  localparam logic [TIME_W-1:0] ECHO_MIN_RST  = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_EDGE    = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_MIN_ECHO  = 2'd1,
    REG_MAX_ECHO  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_RISE = 2'd0,
    PH_FALL = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic {
    CMD_CLOSE   = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic              good;
    logic [TIME_W-1:0] width;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } back_state_e;

endpackage

FILE: rtl/core/epr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_in_if
// event request channel: slot start, edge capture, slot timeout
// ----------------------------------------------------------------------------
interface epr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [epr_pkg::TIME_W-1:0] capture_time;

  modport source (output valid, kind, capture_time, input ready);
  modport sink   (input valid, kind, capture_time, output ready);
endinterface

FILE: rtl/core/epr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_out_if
// measurement result channel
// ----------------------------------------------------------------------------
interface epr_out_if;
  logic                       valid;
  logic                       ready;
  logic [epr_pkg::DIST_W-1:0] distance_centi;
  logic [epr_pkg::CNT_W-1:0]  valid_count;
  logic [epr_pkg::CNT_W-1:0]  fail_count;
  logic                       measure_ok;
  logic [epr_pkg::TOT_W-1:0]  success_total;
  logic [epr_pkg::TOT_W-1:0]  timeout_total;

  modport source (output valid, distance_centi, valid_count, fail_count, measure_ok,
                  success_total, timeout_total, input ready);
  modport sink   (input valid, distance_centi, valid_count, fail_count, measure_ok,
                  success_total, timeout_total, output ready);
endinterface

FILE: rtl/core/epr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface epr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [epr_pkg::CFG_IDX_W-1:0] index;
  logic [epr_pkg::TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/epr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_front
// accepts events, tracks the capture phase and turns closed slots into commands
// ----------------------------------------------------------------------------
module epr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  epr_in_if.sink            evt_i,
  epr_cfg_if.sink           cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output epr_pkg::cmd_t     cmd_o
);

  epr_pkg::phase_e               phase_q, phase_d;
  logic [epr_pkg::TIME_W-1:0]    rise_q, rise_d;
  logic [epr_pkg::TIME_W-1:0]    min_pulse_q, min_echo_q, max_echo_q;
  logic [epr_pkg::TIME_W-1:0]    width;
  logic                          accept;

  assign evt_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = evt_i.valid && evt_i.ready;
  assign width       = evt_i.capture_time - rise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= epr_pkg::MIN_PULSE_RST;
      min_echo_q  <= epr_pkg::MIN_ECHO_RST;
      max_echo_q  <= epr_pkg::MAX_ECHO_RST;
    end else if (cfg_i.valid) begin
      unique case (epr_pkg::cfg_reg_e'(cfg_i.index))
        epr_pkg::REG_MIN_PULSE: min_pulse_q <= cfg_i.data;
        epr_pkg::REG_MIN_ECHO:  min_echo_q  <= cfg_i.data;
        epr_pkg::REG_MAX_ECHO:  max_echo_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    rise_d     = rise_q;
    push_o     = 1'b0;
    cmd_o.op   = epr_pkg::CMD_CLOSE;
    cmd_o.good = (width >= min_echo_q) && (width <= max_echo_q);
    cmd_o.width = width;
    if (accept) begin
      unique case (epr_pkg::event_e'(evt_i.kind))
        epr_pkg::EV_START: begin
          phase_d = epr_pkg::PH_RISE;
        end
        epr_pkg::EV_EDGE: begin
          unique case (phase_q)
            epr_pkg::PH_RISE: begin
              rise_d  = evt_i.capture_time;
              phase_d = epr_pkg::PH_FALL;
            end
            epr_pkg::PH_FALL: begin
              if (width < min_pulse_q) begin
                phase_d = epr_pkg::PH_RISE;
              end else begin
                phase_d = epr_pkg::PH_DONE;
                push_o  = 1'b1;
              end
            end
            default: ;
          endcase
        end
        epr_pkg::EV_TIMEOUT: begin
          if (phase_q != epr_pkg::PH_DONE) begin
            phase_d  = epr_pkg::PH_DONE;
            push_o   = 1'b1;
            cmd_o.op = epr_pkg::CMD_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= epr_pkg::PH_RISE;
      rise_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rise_q  <= rise_d;
    end
  end

endmodule

FILE: rtl/core/epr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_queue
// short command queue between the event front and the measurement back
// ----------------------------------------------------------------------------
module epr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  epr_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output epr_pkg::cmd_t cmd_o
);

  epr_pkg::cmd_t               entries_q [epr_pkg::QDEPTH];
  logic [epr_pkg::QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [epr_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == epr_pkg::QCNT_W'(epr_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entries_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && ready_i;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/epr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_back
// accumulates slot commands, divides the trimmed mean and holds the result
// ----------------------------------------------------------------------------
module epr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  epr_pkg::cmd_t cmd_i,
  epr_out_if.source     res_o
);

  epr_pkg::back_state_e          state_q, state_d;
  logic [epr_pkg::CNT_W-1:0]     slots_q, slots_d, good_q, good_d, fail_q, fail_d;
  logic [epr_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [epr_pkg::TIME_W-1:0]    min_q, min_d, max_q, max_d;
  logic [epr_pkg::TOT_W-1:0]     okm_q, okm_d, tos_q, tos_d;
  logic [epr_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [epr_pkg::DVS_W-1:0]     dvs_q, dvs_d, rem_q, rem_d;
  logic [epr_pkg::STEP_W-1:0]    step_q, step_d;
  logic [epr_pkg::CNT_W-1:0]     sn_good_q, sn_fail_q;
  logic                          sn_ok_q;
  logic [epr_pkg::CNT_W-1:0]     slots_inc;
  logic                          pop, load_out, trim;
  logic [epr_pkg::SUM_W-1:0]     total;
  logic [epr_pkg::CNT_W-1:0]     kcnt;
  logic [epr_pkg::DVS_W:0]       trial;
  logic                          qbit;
  logic                          out_valid_q;

  assign slots_inc = slots_q + 1'b1;
  assign pop       = cmd_valid_i && cmd_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epr_pkg::ST_IDLE: begin
        if (cmd_valid_i && (slots_inc == epr_pkg::CNT_W'(epr_pkg::SAMPLES))) begin
          state_d = epr_pkg::ST_PREP;
        end
      end
      epr_pkg::ST_PREP: state_d = epr_pkg::ST_DIV;
      epr_pkg::ST_DIV: begin
        if (step_q == epr_pkg::STEP_W'(epr_pkg::DIV_STEPS - 1)) begin
          state_d = epr_pkg::ST_EMIT;
        end
      end
      epr_pkg::ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          state_d = epr_pkg::ST_IDLE;
        end
      end
      default: state_d = epr_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_ready_o = (state_q == epr_pkg::ST_IDLE);
    load_out    = (state_q == epr_pkg::ST_EMIT) && (!out_valid_q || res_o.ready);
  end

  // trimmed total and divisor
  assign trim  = (good_q >= epr_pkg::CNT_W'(epr_pkg::TRIM_MIN));
  assign total = trim ? (sum_q - epr_pkg::SUM_W'(min_q) - epr_pkg::SUM_W'(max_q)) : sum_q;
  assign kcnt  = trim ? (good_q - epr_pkg::CNT_W'(2)) : good_q;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[epr_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    slots_d = slots_q;
    good_d  = good_q;
    fail_d  = fail_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    okm_d   = okm_q;
    tos_d   = tos_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      epr_pkg::ST_IDLE: begin
        if (pop) begin
          slots_d = slots_inc;
          if (cmd_i.op == epr_pkg::CMD_TIMEOUT) begin
            fail_d = fail_q + 1'b1;
            tos_d  = tos_q + 1'b1;
          end else if (cmd_i.good) begin
            sum_d  = sum_q + epr_pkg::SUM_W'(cmd_i.width);
            good_d = good_q + 1'b1;
            if (cmd_i.width < min_q) begin
              min_d = cmd_i.width;
            end
            if (cmd_i.width > max_q) begin
              max_d = cmd_i.width;
            end
          end
        end
      end
      epr_pkg::ST_PREP: begin
        // times 17 and times 10 as shift-adds
        dvd_d   = (epr_pkg::DVD_W'(total) << 4) + epr_pkg::DVD_W'(total);
        dvs_d   = (epr_pkg::DVS_W'(kcnt) << 3) + (epr_pkg::DVS_W'(kcnt) << 1);
        rem_d   = '0;
        step_d  = '0;
        okm_d   = (good_q != '0) ? okm_q + 1'b1 : okm_q;
        slots_d = '0;
        good_d  = '0;
        fail_d  = '0;
        sum_d   = '0;
        min_d   = epr_pkg::ECHO_MIN_RST;
        max_d   = '0;
      end
      epr_pkg::ST_DIV: begin
        rem_d  = qbit ? epr_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[epr_pkg::DVS_W-1:0];
        dvd_d  = {dvd_q[epr_pkg::DVD_W-2:0], qbit};
        step_d = step_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= epr_pkg::ST_IDLE;
      slots_q <= '0;
      good_q  <= '0;
      fail_q  <= '0;
      sum_q   <= '0;
      min_q   <= epr_pkg::ECHO_MIN_RST;
      max_q   <= '0;
      okm_q   <= '0;
      tos_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      slots_q <= slots_d;
      good_q  <= good_d;
      fail_q  <= fail_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      okm_q   <= okm_d;
      tos_q   <= tos_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    if (state_q == epr_pkg::ST_PREP) begin
      sn_good_q <= good_q;
      sn_fail_q <= fail_q;
      sn_ok_q   <= (good_q != '0);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_o.distance_centi <= sn_ok_q ? dvd_q[epr_pkg::DIST_W-1:0] : '0;
      res_o.valid_count    <= sn_good_q;
      res_o.fail_count     <= sn_fail_q;
      res_o.measure_ok     <= sn_ok_q;
      res_o.success_total  <= okm_q;
      res_o.timeout_total  <= tos_q;
    end
  end

  assign res_o.valid = out_valid_q;

`include "echo_pulse_trimmed_mean_ranger_assert.svh"

  `EPR_ASSERT_NOW(a_slots_bound, 1'b1,
                  slots_q <= epr_pkg::CNT_W'(epr_pkg::SAMPLES),
                  "slot count past sample count")
  `EPR_ASSERT_NOW(a_counts_fit, 1'b1,
                  ({1'b0, good_q} + {1'b0, fail_q}) <= {1'b0, slots_q},
                  "good plus failed exceeds closed slots")
  `EPR_ASSERT_NEXT(a_emit_loads, (state_q == epr_pkg::ST_EMIT) && !out_valid_q,
                   out_valid_q && (state_q == epr_pkg::ST_IDLE),
                   "free output register not loaded")

endmodule

FILE: rtl/core/echo_pulse_trimmed_mean_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_trimmed_mean_ranger
// echo pulse width ranging with a trimmed mean over a fixed number of slots
// ----------------------------------------------------------------------------
// evt_i carries slot start, edge capture and slot timeout requests; cfg_i
// writes min_pulse, min_echo and max_echo and is always ready; res_o gives
// one result request per five closed slots.
// the front takes one event per cycle while the four-entry command queue has
// room; the back takes a command only while it is idle.
// a command that closes the fifth slot starts the distance step: the prep step
// forms the trimmed total and divisor, the restoring divider then yields one
// quotient bit per cycle, and the emit step loads the output register.
// while the divider runs the back takes no command and the queue fills, after
// which evt_i.ready drops.
// a stalled res_o holds its result; the back waits in its emit step until the
// output register is free, then resumes.
// reset restores the register defaults, opens the first slot and clears all
// counts and totals; no clearing pass is needed.
// ----------------------------------------------------------------------------
module echo_pulse_trimmed_mean_ranger (
  input  logic       clk_i,
  input  logic       rst_ni,
  epr_in_if.sink     evt_i,
  epr_cfg_if.sink    cfg_i,
  epr_out_if.source  res_o
);

  logic          push, full, q_valid, q_ready;
  epr_pkg::cmd_t push_cmd, q_cmd;

  epr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  epr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .cmd_o   (q_cmd)
  );

  epr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_o       (res_o)
  );

endmodule
